// ----- rtl/sua_pkg.sv -----
// package for the integer alu: opcodes, field widths and transaction structs
// no dependencies
package sua_pkg;
  localparam int OpW = 5;
  localparam int FieldW = 32;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_EQ = 5'd5, OP_NE = 5'd6, OP_LE = 5'd7, OP_GE = 5'd8, OP_LT = 5'd9,
    OP_GT = 5'd10, OP_AND = 5'd11, OP_OR = 5'd12, OP_XOR = 5'd13,
    OP_ASR = 5'd14, OP_ASL = 5'd15, OP_UMUL = 5'd16, OP_UDIV = 5'd17,
    OP_UMOD = 5'd18, OP_ULE = 5'd19, OP_UGE = 5'd20, OP_ULT = 5'd21,
    OP_UGT = 5'd22
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]    opcode;
    logic [FieldW-1:0] left_operand;
    logic [FieldW-1:0] right_operand;
  } req_t;

  typedef struct packed {
    logic [FieldW-1:0] result_value;
    logic              divide_by_zero;
  } rsp_t;

  // control that travels down the divider chain beside the data
  typedef struct packed {
    logic    vld;
    logic    is_div;
    logic    dz;
    logic    neg_q;
    logic    neg_r;
    logic    want_rem;
  } div_ctl_t;
endpackage

// ----- rtl/sua_if.sv -----
// valid/ready channel carrying a payload struct
// no dependencies
interface sua_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sua_div_cell.sv -----
// one restoring-division cell: one quotient bit per cycle while en_i is high, hands on to the next cell
// depends on sua_pkg
module sua_div_cell #(
  parameter int W = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  sua_pkg::div_ctl_t    ctl_i,
  input  logic [W-1:0]         rem_i,
  input  logic [W-1:0]         num_i,
  input  logic [W-1:0]         den_i,
  input  logic [W-1:0]         alt_i,
  output sua_pkg::div_ctl_t    ctl_o,
  output logic [W-1:0]         rem_o,
  output logic [W-1:0]         num_o,
  output logic [W-1:0]         den_o,
  output logic [W-1:0]         alt_o
);
  import sua_pkg::*;
  logic [W:0]   trial;
  logic [W:0]   diff;
  logic [W-1:0] rem_d, num_d;
  div_ctl_t     ctl_q;
  logic [W-1:0] rem_q, num_q, den_q, alt_q;

  always_comb begin
    trial = {rem_i, num_i[W-1]};
    diff  = trial - {1'b0, den_i};
    if (!diff[W]) begin
      rem_d = diff[W-1:0];
      num_d = {num_i[W-2:0], 1'b1};
    end else begin
      rem_d = trial[W-1:0];
      num_d = {num_i[W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      den_q <= den_i;
      alt_q <= alt_i;
    end
  end

  assign ctl_o = ctl_q;
  assign rem_o = rem_q;
  assign num_o = num_q;
  assign den_o = den_q;
  assign alt_o = alt_q;
endmodule

// ----- rtl/signed_unsigned_integer_alu_top.sv -----
// integer alu top level: operand decode, division cell chain, output register
// depends on sua_pkg, sua_if, sua_div_cell
//
// usage: operations enter on in_if (opcode and two operands) and leave on
// out_if (result and divide-by-zero flag), one result per transaction, in order.
// every operation passes the same pipeline: one entry stage, WIDTH division
// cells (one quotient bit each) and one output stage, for all opcodes.
// one transaction is accepted per cycle while the chain advances.
// non-divide results ride the chain unchanged beside the divider data; the
// low product bits of a multiply are formed in the entry stage.
// when the receiver stalls the whole chain holds and in_if.ready falls;
// the chain advances whenever the output register is empty or being taken.
// reset clears all valid bits; no item is in flight afterwards.
module signed_unsigned_integer_alu_top #(
  parameter int WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  sua_if.sink   in_if,
  sua_if.source out_if
);
  import sua_pkg::*;
  localparam int ShW = $clog2(WIDTH);
  localparam int N = WIDTH;

  logic adv;
  logic out_vld_q;
  rsp_t out_q;

  // entry decode
  logic [WIDTH-1:0] a, b, ma, mb, res_d, sha;
  logic [WIDTH-1:0] prod;
  logic             na, nb, slt_ab, slt_ba, ult, ugt;
  logic [ShW-1:0]   sh;
  div_ctl_t         ctl_d;
  op_e              op;

  assign a = in_if.data.left_operand[WIDTH-1:0];
  assign b = in_if.data.right_operand[WIDTH-1:0];
  assign op = op_e'(in_if.data.opcode);
  assign na = a[WIDTH-1];
  assign nb = b[WIDTH-1];
  assign sh = b[ShW-1:0];
  assign slt_ab = $signed(a) < $signed(b);
  assign slt_ba = $signed(b) < $signed(a);
  assign ult = a < b;
  assign ugt = b < a;
  assign prod = a * b;
  assign sha = $unsigned($signed(a) >>> sh);

  always_comb begin
    ctl_d = '0;
    ctl_d.vld = in_if.valid;
    ma = a;
    mb = b;
    res_d = '0;
    case (op)
      OP_ADD: res_d = a + b;
      OP_SUB: res_d = a - b;
      OP_MUL, OP_UMUL: res_d = prod;
      OP_DIV, OP_MOD: begin
        ctl_d.is_div = 1'b1;
        ctl_d.want_rem = (op == OP_MOD);
        ma = na ? (~a + 1'b1) : a;
        mb = nb ? (~b + 1'b1) : b;
        ctl_d.neg_q = na ^ nb;
        ctl_d.neg_r = na;
      end
      OP_UDIV, OP_UMOD: begin
        ctl_d.is_div = 1'b1;
        ctl_d.want_rem = (op == OP_UMOD);
      end
      OP_EQ: res_d = WIDTH'(a == b);
      OP_NE: res_d = WIDTH'(a != b);
      OP_LE: res_d = WIDTH'(!slt_ba);
      OP_GE: res_d = WIDTH'(!slt_ab);
      OP_LT: res_d = WIDTH'(slt_ab);
      OP_GT: res_d = WIDTH'(slt_ba);
      OP_AND: res_d = a & b;
      OP_OR: res_d = a | b;
      OP_XOR: res_d = a ^ b;
      OP_ASR: res_d = sha;
      OP_ASL: res_d = a << sh;
      OP_ULE: res_d = WIDTH'(!ugt);
      OP_UGE: res_d = WIDTH'(!ult);
      OP_ULT: res_d = WIDTH'(ult);
      OP_UGT: res_d = WIDTH'(ugt);
      default: res_d = '0;
    endcase
    if (ctl_d.is_div) begin
      ctl_d.dz = (b == '0);
      res_d = a;
    end
  end

  // cell chain: index 0 is the entry register
  div_ctl_t         c_ctl [N+1];
  logic [WIDTH-1:0] c_rem [N+1];
  logic [WIDTH-1:0] c_num [N+1];
  logic [WIDTH-1:0] c_den [N+1];
  logic [WIDTH-1:0] c_alt [N+1];

  div_ctl_t         e_ctl_q;
  logic [WIDTH-1:0] e_num_q, e_den_q, e_alt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_ctl_q <= '0;
    end else if (adv) begin
      e_ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_num_q <= ma;
      e_den_q <= mb;
      e_alt_q <= res_d;
    end
  end

  assign c_ctl[0] = e_ctl_q;
  assign c_rem[0] = '0;
  assign c_num[0] = e_num_q;
  assign c_den[0] = e_den_q;
  assign c_alt[0] = e_alt_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    sua_div_cell #(.W(WIDTH)) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .ctl_i (c_ctl[i]),
      .rem_i (c_rem[i]),
      .num_i (c_num[i]),
      .den_i (c_den[i]),
      .alt_i (c_alt[i]),
      .ctl_o (c_ctl[i+1]),
      .rem_o (c_rem[i+1]),
      .num_o (c_num[i+1]),
      .den_o (c_den[i+1]),
      .alt_o (c_alt[i+1])
    );
  end

  // output stage
  div_ctl_t         t_ctl;
  logic [WIDTH-1:0] q_raw, r_raw, fin;
  assign t_ctl = c_ctl[N];
  assign q_raw = c_num[N];
  assign r_raw = c_rem[N];

  always_comb begin
    fin = c_alt[N];
    if (t_ctl.is_div) begin
      if (t_ctl.dz) begin
        fin = t_ctl.want_rem ? c_alt[N] : '1;
      end else if (t_ctl.want_rem) begin
        fin = t_ctl.neg_r ? (~r_raw + 1'b1) : r_raw;
      end else begin
        fin = t_ctl.neg_q ? (~q_raw + 1'b1) : q_raw;
      end
    end
  end

  assign adv = !out_vld_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= t_ctl.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.result_value   <= FieldW'(fin);
      out_q.divide_by_zero <= t_ctl.is_div & t_ctl.dz;
    end
  end

  assign in_if.ready  = adv;
  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;
endmodule
